[rtl/ple_pkg.sv]
// Shared types and codes for the positional list engine.
`default_nettype none
package ple_pkg;

	localparam logic [1:0] OP_INS = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_RD  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic       load;
		logic       fetch;
		logic       grab;
		logic       init_ins;
		logic       init_del;
		logic       step;
		logic       put;
		logic       len_inc;
		logic       len_dec;
		logic       set_st;
		logic [1:0] st;
	} ple_cmd_t;

	typedef struct packed {
		logic bad;
		logic full;
		logic more;
		logic is_ins;
		logic is_del;
	} ple_stat_t;

endpackage
`default_nettype wire

[rtl/ple_dp.sv]
// Datapath of the positional list engine: request registers, store and shift pipeline.
`default_nettype none
module ple_dp #(
	parameter int CAPACITY = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         opcode,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value_in,
	input  wire ple_pkg::ple_cmd_t  cmd,
	output ple_pkg::ple_stat_t      stat,
	output logic [1:0]              status,
	output logic signed [31:0]      value_out,
	output logic [7:0]              length_now
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > 8) ? LW : 8) + 1;

	logic [31:0]   mem [CAPACITY];
	logic [1:0]    op_q;
	logic [7:0]    pos_q;
	logic [31:0]   word_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] idx_q;
	logic [1:0]    status_q;
	logic [31:0]   val_q;
	logic [31:0]   rdata_s1;
	logic          pend_s1;
	logic [AW-1:0] dst_s1;

	logic [CW-1:0] pos_w, len_w, idx_w, pm1_w, im1_w;
	logic          is_ins, is_del, is_rd;
	logic          rd_en;
	logic [AW-1:0] rd_addr, step_dst;

	always_comb begin
		pos_w  = CW'(pos_q);
		len_w  = CW'(len_q);
		idx_w  = CW'(idx_q);
		pm1_w  = pos_w - CW'(1);
		im1_w  = idx_w - CW'(1);
		is_ins = (op_q == ple_pkg::OP_INS);
		is_del = (op_q == ple_pkg::OP_DEL);
		is_rd  = (op_q == ple_pkg::OP_RD);
	end

	always_comb begin
		stat.is_ins = is_ins;
		stat.is_del = is_del;
		stat.full   = (len_q == LW'(CAPACITY));
		stat.more   = is_ins ? (idx_w >= pos_w) : (idx_w < len_w);
		if (pos_q == 8'd0) begin
			stat.bad = 1'b1;
		end else if (is_ins) begin
			stat.bad = (pos_w > len_w + CW'(1));
		end else if (is_del || is_rd) begin
			stat.bad = (pos_w > len_w);
		end else begin
			stat.bad = 1'b1;
		end
	end

	// insert moves entry idx-1 up to idx; delete moves entry idx down to idx-1
	always_comb begin
		rd_en    = cmd.fetch | cmd.step;
		step_dst = is_ins ? idx_w[AW-1:0] : im1_w[AW-1:0];
		if (cmd.fetch) begin
			rd_addr = pm1_w[AW-1:0];
		end else if (is_ins) begin
			rd_addr = im1_w[AW-1:0];
		end else begin
			rd_addr = idx_w[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (cmd.put) begin
			mem[pm1_w[AW-1:0]] <= word_q;
		end else if (pend_s1) begin
			mem[dst_s1] <= rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			pos_q  <= position;
			word_q <= value_in;
			val_q  <= '0;
		end
		if (cmd.grab) begin
			val_q <= rdata_s1;
		end
		if (cmd.init_ins) begin
			idx_q <= len_q;
		end else if (cmd.init_del) begin
			idx_q <= pos_w[LW-1:0];
		end else if (cmd.step) begin
			idx_q <= is_ins ? (idx_q - LW'(1)) : (idx_q + LW'(1));
		end
		if (cmd.step) begin
			dst_s1 <= step_dst;
		end
		if (cmd.set_st) begin
			status_q <= cmd.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.step;
			if (cmd.len_inc) begin
				len_q <= len_q + LW'(1);
			end else if (cmd.len_dec) begin
				len_q <= len_q - LW'(1);
			end
		end
	end

	assign status     = status_q;
	assign value_out  = val_q;
	assign length_now = len_w[7:0];

endmodule
`default_nettype wire

[rtl/ple_ctrl.sv]
// Controller state machine of the positional list engine.
`default_nettype none
module ple_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire ple_pkg::ple_stat_t stat,
	output ple_pkg::ple_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_GRAB  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		cmd.st  = ple_pkg::ST_OK;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.bad) begin
					cmd.set_st = 1'b1;
					cmd.st     = ple_pkg::ST_BADPOS;
					state_d    = S_RESP;
				end else if (stat.is_ins && stat.full) begin
					cmd.set_st = 1'b1;
					cmd.st     = ple_pkg::ST_FULL;
					state_d    = S_RESP;
				end else if (stat.is_ins) begin
					cmd.init_ins = 1'b1;
					state_d      = S_SHIFT;
				end else begin
					cmd.fetch = 1'b1;
					state_d   = S_GRAB;
				end
			end
			S_GRAB: begin
				cmd.grab = 1'b1;
				if (stat.is_del) begin
					cmd.init_del = 1'b1;
					state_d      = S_SHIFT;
				end else begin
					cmd.set_st = 1'b1;
					state_d    = S_RESP;
				end
			end
			S_SHIFT: begin
				if (stat.more) begin
					cmd.step = 1'b1;
				end else if (stat.is_ins) begin
					state_d = S_PUT;
				end else begin
					cmd.len_dec = 1'b1;
					cmd.set_st  = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_PUT: begin
				cmd.put     = 1'b1;
				cmd.len_inc = 1'b1;
				cmd.set_st  = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule
`default_nettype wire

[rtl/positional_list_engine.sv]
// Top level of the positional list engine: controller plus datapath.
//
// Keeps an ordered list of signed 32-bit words in a single-port-write store of
// CAPACITY entries. Raise start while busy is low to hand over one transaction
// (opcode, position, value_in); busy then stays high until the result has been
// shown. The result appears for exactly one cycle with done high and cannot be
// held off, so capture status, value_out and length_now on that cycle.
// A rejected request (bad position, unused opcode, insert into a full store)
// goes from the check straight to the result; a read also fetches the entry,
// a delete fetches and then shifts the tail down, and an insert shifts the
// tail up and then stores the new word. Busy falls after the done cycle, and
// the next transaction is accepted from the idle state. The shifts move one
// entry per cycle through the store's one write port. Length is cleared by
// reset; store contents are not, and need not be, since only written entries
// are ever read.
`default_nettype none
module positional_list_engine #(
	parameter int CAPACITY = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      value_out,
	output logic [7:0]              length_now
);

	ple_pkg::ple_cmd_t  cmd;
	ple_pkg::ple_stat_t stat;

	// sequence the request: check, fetch, shift, store, respond
	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold the request, the store and the result registers
	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.position   (position),
		.value_in   (value_in),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status),
		.value_out  (value_out),
		.length_now (length_now)
	);

endmodule
`default_nettype wire

[rtl/ple_checker.sv]
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none
module ple_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic [1:0]         status,
	input wire logic signed [31:0] value_out,
	input wire logic [7:0]         length_now
);

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// the result strobe lasts one cycle and frees the block
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done not followed by idle");

	// a result only comes while a transaction is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// a failed transaction returns no word and leaves the length unchanged
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ple_pkg::ST_OK |-> value_out == 32'sd0
			&& length_now == $past(length_now, 2))
		else $error("failed transaction changed state or returned data");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.value_out  (value_out),
	.length_now (length_now)
);
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	// Opcode three has no name in the package; the block must reject it.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CAPACITY = 128;
	// Even with every insert shifting the whole store and the longest sender
	// gaps, roughly 500 transactions fit well inside this.
	localparam int CYCLE_LIMIT = 1_000_000;
	// This settling time covers any trailing activity after the last result.
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic [7:0]         length;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         opcode;
	logic [7:0]         position;
	logic signed [31:0] value_in;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] value_out;
	logic [7:0]         length_now;

	// Our own copy of the list, kept in step with every accepted transaction.
	logic signed [31:0] list_copy [CAPACITY];
	int                 list_count;
	outcome_t           pending_outcomes [$];
	int                 error_count;
	int                 cycle_count;
	int                 burst_left;

	positional_list_engine #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.position(position),
		.value_in(value_in),
		.done(done),
		.status(status),
		.value_out(value_out),
		.length_now(length_now)
	);

	always #1 clk = ~clk;

	// Work out the result of one request and update the list copy to match.
	// The position check comes before the full check, as in the block.
	function automatic outcome_t apply_request(input logic [1:0] op, input logic [7:0] pos,
		input logic signed [31:0] word);
		outcome_t res;
		int       p;
		p = int'(pos);
		res.status = ple_pkg::ST_OK;
		res.value = '0;
		case (op)
			ple_pkg::OP_INS: begin
				if (p < 1 || p > list_count + 1) begin
					res.status = ple_pkg::ST_BADPOS;
				end else if (list_count >= CAPACITY) begin
					res.status = ple_pkg::ST_FULL;
				end else begin
					// Shift the tail up by one, then drop the new word into the gap.
					for (int k = list_count; k > p - 1; k--)
						list_copy[k] = list_copy[k - 1];
					list_copy[p - 1] = word;
					list_count++;
				end
			end
			ple_pkg::OP_DEL: begin
				if (p < 1 || p > list_count) begin
					res.status = ple_pkg::ST_BADPOS;
				end else begin
					res.value = list_copy[p - 1];
					for (int k = p; k < list_count; k++)
						list_copy[k - 1] = list_copy[k];
					list_count--;
				end
			end
			ple_pkg::OP_RD: begin
				if (p < 1 || p > list_count)
					res.status = ple_pkg::ST_BADPOS;
				else
					res.value = list_copy[p - 1];
			end
			default: begin
				res.status = ple_pkg::ST_BADPOS;
			end
		endcase
		res.length = list_count[7:0];
		return res;
	endfunction

	// Check each result against the oldest expectation, then record any
	// transaction accepted on this edge. Both read the values from before
	// the edge, so no ordering within the time step matters.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with nothing expected: status %0d value %0d length %0d",
					status, value_out, length_now);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (value_out !== want.value) begin
					$error("value_out: expected %0d, got %0d", want.value, value_out);
					error_count++;
				end
				if (length_now !== want.length) begin
					$error("length_now: expected %0d, got %0d", want.length, length_now);
					error_count++;
				end
			end
		end
		if (arst_n && start && !busy)
			pending_outcomes.push_back(apply_request(opcode, position, value_in));
	end

	// Watchdog: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Hand over one transaction. Called and returning at a falling edge.
	// The sender works in bursts: once a burst runs out, drop start for a
	// random gap - usually short, now and then long enough to span a shift.
	task automatic send_request(input logic [1:0] op, input logic [7:0] pos,
		input logic signed [31:0] word);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			// Some bursts are long, giving stretches with no gaps at all.
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		start <= 1'b1;
		opcode <= op;
		position <= pos;
		value_in <= word;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly random words, with the extremes mixed in.
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// A position for the given opcode: legal most of the time, otherwise one
	// just outside the range, zero, or anything at all.
	function automatic logic [7:0] pick_position(input logic [1:0] op);
		int upper;
		upper = (op == ple_pkg::OP_INS) ? list_count + 1 : list_count;
		if (upper >= 1 && $urandom_range(0, 99) < 85)
			return 8'($urandom_range(1, upper));
		case ($urandom_range(0, 2))
			0: return 8'd0;
			1: return (upper + 1 > 255) ? 8'd255 : 8'(upper + 1);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Extremes of position and value, every opcode and bad-position rejections on a
	// short list, ending with the list empty again.
	task automatic test_edge_positions();
		send_request(ple_pkg::OP_RD, 8'd1, 32'sd5);
		send_request(ple_pkg::OP_DEL, 8'd1, 32'sd5);
		send_request(ple_pkg::OP_INS, 8'd0, 32'sd9);
		send_request(ple_pkg::OP_INS, 8'd2, 32'sd9);
		send_request(OP_UNUSED, 8'd1, 32'sd9);
		send_request(ple_pkg::OP_INS, 8'd1, 32'sh7fffffff);
		send_request(ple_pkg::OP_INS, 8'd2, 32'sh80000000);
		send_request(ple_pkg::OP_INS, 8'd1, -32'sd1);
		send_request(ple_pkg::OP_INS, 8'd2, 32'sd0);
		send_request(ple_pkg::OP_INS, 8'd255, 32'sh5a5a5a5a);
		for (int p = 1; p <= 5; p++)
			send_request(ple_pkg::OP_RD, 8'(p), 32'shffffffff);
		send_request(ple_pkg::OP_DEL, 8'd5, 32'sd0);
		send_request(ple_pkg::OP_RD, 8'd255, 32'sd0);
		send_request(ple_pkg::OP_DEL, 8'd0, 32'sd0);
		send_request(OP_UNUSED, 8'd0, 32'sh7fffffff);
		send_request(ple_pkg::OP_DEL, 8'd4, 32'sd0);
		send_request(ple_pkg::OP_DEL, 8'd1, 32'sd0);
		send_request(ple_pkg::OP_DEL, 8'd1, 32'sd0);
		send_request(ple_pkg::OP_DEL, 8'd1, 32'sd0);
	endtask

	// Fill the store to capacity, poke at the full store, then drain it.
	task automatic test_full_store();
		while (list_count < CAPACITY)
			send_request(ple_pkg::OP_INS, 8'($urandom_range(1, list_count + 1)), pick_word());
		// A legal position on a full store reports full; an illegal one
		// reports bad position, since position is checked first.
		send_request(ple_pkg::OP_INS, 8'd1, pick_word());
		send_request(ple_pkg::OP_INS, 8'(CAPACITY + 1), pick_word());
		send_request(ple_pkg::OP_INS, 8'(CAPACITY + 2), pick_word());
		send_request(ple_pkg::OP_INS, 8'd255, pick_word());
		send_request(ple_pkg::OP_INS, 8'd0, pick_word());
		send_request(ple_pkg::OP_RD, 8'(CAPACITY), pick_word());
		send_request(ple_pkg::OP_RD, 8'(CAPACITY + 1), pick_word());
		send_request(ple_pkg::OP_DEL, 8'(CAPACITY), pick_word());
		send_request(ple_pkg::OP_INS, 8'(CAPACITY), pick_word());
		send_request(ple_pkg::OP_DEL, 8'd1, pick_word());
		send_request(ple_pkg::OP_INS, 8'd1, pick_word());
		// Drain with random deletes, reading a random entry now and then.
		while (list_count > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_request(ple_pkg::OP_RD, 8'($urandom_range(1, list_count)), pick_word());
			send_request(ple_pkg::OP_DEL, 8'($urandom_range(1, list_count)), pick_word());
		end
	endtask

	// Random mix of requests. Inserts and deletes take near-equal shares,
	// swapped once the list holds more than 96 entries.
	task automatic test_random_mix(input int count);
		logic [1:0] op;
		int         roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				op = OP_UNUSED;
			else if (roll < 25)
				op = ple_pkg::OP_RD;
			else if (roll < 62)
				op = (list_count > 96) ? ple_pkg::OP_DEL : ple_pkg::OP_INS;
			else
				op = (list_count > 96) ? ple_pkg::OP_INS : ple_pkg::OP_DEL;
			// Push up against the full store for a while when it gets close.
			if (list_count >= CAPACITY - 4 && $urandom_range(0, 1) == 0)
				op = ple_pkg::OP_INS;
			send_request(op, pick_position(op), pick_word());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = ple_pkg::OP_INS;
		position = '0;
		value_in = '0;
		list_count = 0;
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_edge_positions();
		test_full_store();
		test_random_mix(180);

		// Drop start, wait for every result, then let the block settle.
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

[positional_list_engine.f]
rtl/ple_pkg.sv
rtl/ple_dp.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
rtl/ple_checker.sv
tb/testbench.sv
